// File: rtl/mosc_pkg.sv
// ----------------------------------------------------------------------------
// mosc_pkg
// Shared types and constants for the memory operand scope classifier:
// opcode and prefix bytes, scope codes, region offsets and stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mosc_pkg;

   localparam int unsigned NUM_BYTES   = 32;
   localparam int unsigned BYTE_IDX_W  = $clog2(NUM_BYTES);
   localparam int unsigned POS_W       = 7;
   localparam int unsigned FETCH_BYTES = 4;

   localparam logic [7:0] PFX_OPSIZE  = 8'h66;
   localparam logic [7:0] PFX_ADSIZE  = 8'h67;
   localparam logic [7:0] PFX_LOCK    = 8'hF0;
   localparam logic [7:0] PFX_REPNE   = 8'hF2;
   localparam logic [7:0] PFX_REP     = 8'hF3;
   localparam logic [3:0] REX_NIBBLE  = 4'h4;
   localparam logic [7:0] OPC_ESCAPE  = 8'h0F;
   localparam logic [7:0] OPC_MOV_LD  = 8'h8B;
   localparam logic [7:0] OPC_MOV_AX  = 8'hA1;
   localparam logic [5:0] OPC_MOFFS_HI = 6'b101000;

   localparam logic [1:0] MOD_REG     = 2'd3;
   localparam logic [1:0] MOD_NODISP  = 2'd0;
   localparam logic [2:0] RM_SIB      = 3'd4;
   localparam logic [2:0] RM_DISP32   = 3'd5;
   localparam logic [3:0] REG_RSP     = 4'd4;
   localparam logic [3:0] REG_RBP     = 4'd5;

   localparam logic [2:0] SCOPE_NORMAL  = 3'd0;
   localparam logic [2:0] SCOPE_POINTER = 3'd1;
   localparam logic [2:0] SCOPE_STACK   = 3'd2;
   localparam logic [2:0] SCOPE_GLOBAL  = 3'd3;
   localparam logic [2:0] SCOPE_ARRAY   = 3'd4;

   localparam logic [41:0] REGION_POINTER = 42'h0;
   localparam logic [41:0] REGION_STACK   = 42'h010000000000;
   localparam logic [41:0] REGION_GLOBAL  = 42'h020000000000;
   localparam logic [41:0] REGION_ARRAY   = 42'h030000000000;
   localparam logic [41:0] REGION_NORMAL  = 42'h001000000000;

   localparam logic [15:0] STEP_DEFAULT = 16'd64;
   localparam logic [7:0]  STEP_MIN     = 8'd8;

   localparam logic ADDR_STREAM_PADDING = 1'b0;

   typedef logic [NUM_BYTES-1:0][7:0] instr_bytes_type;

   typedef struct packed {
      instr_bytes_type   bytes;
      logic [NUM_BYTES-1:0] rex;
      logic [POS_W-1:0]  len;
      logic [POS_W-1:0]  at;
      logic [6:0]        acc;
   } scan_type;

   typedef struct packed {
      logic [FETCH_BYTES-1:0]      avail;
      logic [FETCH_BYTES-1:0][7:0] win;
      logic                        rb;
      logic                        rx;
      logic [6:0]                  acc;
   } fetch_type;

   typedef struct packed {
      logic       found;
      logic       idx;
      logic       stk;
      logic       rip;
      logic [3:0] scale;
      logic       hint;
      logic [6:0] acc;
   } shape_type;

endpackage

`default_nettype wire

// File: rtl/mosc_prefix_scan.sv
// ----------------------------------------------------------------------------
// mosc_prefix_scan
// Two stages: classify every byte as legacy prefix or rex and clamp the
// length, then find the first byte past the prefix run.
// ----------------------------------------------------------------------------
`default_nettype none

module mosc_prefix_scan
   import mosc_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [63:0] bytes_lo,
   input  logic [63:0] bytes_mid_lo,
   input  logic [63:0] bytes_mid_hi,
   input  logic [63:0] bytes_hi,
   input  logic [5:0]  byte_count,
   input  logic [6:0]  access_bytes,
   output logic        out_valid,
   output scan_type    out_data,
   input  logic        out_ready
);

   localparam logic [POS_W-1:0] LEN_LIMIT = POS_W'(MAX_BYTES);

   logic                 v1_ff;
   instr_bytes_type      bytes1_ff, bytes1_in;
   logic [NUM_BYTES-1:0] pfx1_ff, pfx1_in;
   logic [NUM_BYTES-1:0] rex1_ff, rex1_in;
   logic [POS_W-1:0]     len1_ff, len1_in;
   logic [6:0]           acc1_ff;
   logic                 v2_ff;
   scan_type             scan2_ff, scan2_in;
   logic                 ready1, ready2;
   logic [POS_W-1:0]     first_np;
   logic [POS_W-1:0]     count_ext;

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   always_comb begin
      bytes1_in = instr_bytes_type'({bytes_hi, bytes_mid_hi, bytes_mid_lo, bytes_lo});
      for (int k = 0; k < NUM_BYTES; k++) begin
         rex1_in[k] = bytes1_in[k][7:4] == REX_NIBBLE;
         pfx1_in[k] = rex1_in[k] || bytes1_in[k] == PFX_OPSIZE
                      || bytes1_in[k] == PFX_ADSIZE || bytes1_in[k] == PFX_LOCK
                      || bytes1_in[k] == PFX_REPNE || bytes1_in[k] == PFX_REP;
      end
      count_ext = POS_W'(byte_count);
      len1_in   = (count_ext > LEN_LIMIT) ? LEN_LIMIT : count_ext;
   end

   always_comb begin
      first_np = POS_W'(NUM_BYTES);
      for (int k = NUM_BYTES - 1; k >= 0; k--) begin
         if (!pfx1_ff[k]) begin
            first_np = POS_W'(k);
         end
      end
      scan2_in.bytes = bytes1_ff;
      scan2_in.rex   = rex1_ff;
      scan2_in.len   = len1_ff;
      scan2_in.at    = (first_np < len1_ff) ? first_np : len1_ff;
      scan2_in.acc   = acc1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= in_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         bytes1_ff <= bytes1_in;
         pfx1_ff   <= pfx1_in;
         rex1_ff   <= rex1_in;
         len1_ff   <= len1_in;
         acc1_ff   <= access_bytes;
      end
      if (ready2 && v1_ff) begin
         scan2_ff <= scan2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = scan2_ff;

endmodule

`default_nettype wire

// File: rtl/mosc_shape_decode.sv
// ----------------------------------------------------------------------------
// mosc_shape_decode
// Two stages: fetch opcode, modrm and sib candidates and the last rex bits,
// then decode the memory operand shape.
// ----------------------------------------------------------------------------
`default_nettype none

module mosc_shape_decode
   import mosc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  scan_type  in_data,
   output logic      out_valid,
   output shape_type out_data,
   input  logic      out_ready
);

   logic       v3_ff, v4_ff;
   fetch_type  fetch3_ff, fetch3_in;
   shape_type  shape4_ff, shape4_in;
   logic       ready3, ready4;
   logic [POS_W-1:0] pos;
   logic [7:0] op, modrm, sib;
   logic       mod_ok, sib_ok, is_esc;
   logic [1:0] md;
   logic [2:0] rm, il, bl;

   assign ready4   = !v4_ff || out_ready;
   assign ready3   = !v3_ff || ready4;
   assign in_ready = ready3;

   always_comb begin
      pos = '0;
      fetch3_in.rb  = 1'b0;
      fetch3_in.rx  = 1'b0;
      fetch3_in.acc = in_data.acc;
      for (int j = 0; j < FETCH_BYTES; j++) begin
         pos = in_data.at + POS_W'(j);
         fetch3_in.avail[j] = pos < in_data.len;
         fetch3_in.win[j]   = (pos < POS_W'(NUM_BYTES))
                              ? in_data.bytes[pos[BYTE_IDX_W-1:0]] : 8'h00;
      end
      for (int k = 0; k < NUM_BYTES; k++) begin
         if (in_data.rex[k] && POS_W'(k) < in_data.at) begin
            fetch3_in.rb = in_data.bytes[k][0];
            fetch3_in.rx = in_data.bytes[k][1];
         end
      end
   end

   always_comb begin
      op     = fetch3_ff.win[0];
      is_esc = op == OPC_ESCAPE;
      modrm  = is_esc ? fetch3_ff.win[2] : fetch3_ff.win[1];
      sib    = is_esc ? fetch3_ff.win[3] : fetch3_ff.win[2];
      mod_ok = is_esc ? fetch3_ff.avail[2] : fetch3_ff.avail[1];
      sib_ok = is_esc ? fetch3_ff.avail[3] : fetch3_ff.avail[2];
      md     = modrm[7:6];
      rm     = modrm[2:0];
      il     = sib[5:3];
      bl     = sib[2:0];

      shape4_in.found = 1'b0;
      shape4_in.idx   = 1'b0;
      shape4_in.stk   = 1'b0;
      shape4_in.rip   = 1'b0;
      shape4_in.scale = 4'd1;
      shape4_in.acc   = fetch3_ff.acc;
      shape4_in.hint  = fetch3_ff.avail[0] && (op == OPC_MOV_LD || op == OPC_MOV_AX);

      if (fetch3_ff.avail[0]) begin
         if (op[7:2] == OPC_MOFFS_HI) begin
            shape4_in.found = 1'b1;
         end else if (mod_ok && md != MOD_REG) begin
            if (rm == RM_SIB) begin
               if (sib_ok) begin
                  shape4_in.found = 1'b1;
                  shape4_in.scale = 4'd1 << sib[7:6];
                  shape4_in.idx   = {fetch3_ff.rx, il} != REG_RSP;
                  shape4_in.stk   = ({fetch3_ff.rb, bl} == REG_RSP
                                     || {fetch3_ff.rb, bl} == REG_RBP)
                                    && !(md == MOD_NODISP && bl == RM_DISP32);
               end
            end else begin
               shape4_in.found = 1'b1;
               if (md == MOD_NODISP && rm == RM_DISP32) begin
                  shape4_in.rip = 1'b1;
               end else if ({fetch3_ff.rb, rm} == REG_RSP
                            || {fetch3_ff.rb, rm} == REG_RBP) begin
                  shape4_in.stk = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready3) begin
            v3_ff <= in_valid;
         end
         if (ready4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && in_valid) begin
         fetch3_ff <= fetch3_in;
      end
      if (ready4 && v3_ff) begin
         shape4_ff <= shape4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = shape4_ff;

endmodule

`default_nettype wire

// File: rtl/mosc_scope_classify.sv
// ----------------------------------------------------------------------------
// mosc_scope_classify
// Output stage: picks the scope from the decoded shape and access size,
// and registers the result beat with its region offset and stream step.
// ----------------------------------------------------------------------------
`default_nettype none

module mosc_scope_classify
   import mosc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  shape_type   in_data,
   input  logic [15:0] stream_padding,
   output logic        out_valid,
   input  logic        out_stall,
   output logic [2:0]  out_scope,
   output logic        out_shape_found,
   output logic        out_has_index_reg,
   output logic        out_stack_based,
   output logic        out_rip_relative,
   output logic [3:0]  out_scale_factor,
   output logic [41:0] out_region_offset,
   output logic [15:0] out_stream_step
);

   logic        v5_ff;
   logic [2:0]  scope_ff, scope_in;
   logic        found_ff, idx_ff, stk_ff, rip_ff;
   logic [3:0]  scale_ff;
   logic [41:0] region_ff, region_in;
   logic [15:0] step_ff, step_in;
   logic        ready5;
   logic [15:0] pad;
   logic [7:0]  width;
   logic [15:0] width_ext;

   assign ready5   = !v5_ff || !out_stall;
   assign in_ready = ready5;

   always_comb begin
      if (in_data.stk) begin
         scope_in = SCOPE_STACK;
      end else if (in_data.rip) begin
         scope_in = SCOPE_GLOBAL;
      end else if (in_data.idx) begin
         scope_in = SCOPE_ARRAY;
      end else if (in_data.acc < 7'd8) begin
         scope_in = SCOPE_NORMAL;
      end else if (in_data.found || in_data.hint) begin
         scope_in = SCOPE_POINTER;
      end else begin
         scope_in = SCOPE_NORMAL;
      end

      pad       = (stream_padding == 16'd0) ? STEP_DEFAULT : stream_padding;
      width     = (in_data.acc == 7'd0) ? STEP_MIN
                  : ((8'(in_data.acc) + 8'd7) & 8'hF8);
      width_ext = 16'(width);

      unique case (scope_in)
         SCOPE_POINTER: begin
            region_in = REGION_POINTER;
            step_in   = pad;
         end
         SCOPE_STACK: begin
            region_in = REGION_STACK;
            step_in   = 16'd0;
         end
         SCOPE_GLOBAL: begin
            region_in = REGION_GLOBAL;
            step_in   = 16'd0;
         end
         SCOPE_ARRAY: begin
            region_in = REGION_ARRAY;
            step_in   = (width_ext > pad) ? width_ext : pad;
         end
         default: begin
            region_in = REGION_NORMAL;
            step_in   = 16'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (ready5) begin
         v5_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready5 && in_valid) begin
         scope_ff  <= scope_in;
         found_ff  <= in_data.found;
         idx_ff    <= in_data.idx;
         stk_ff    <= in_data.stk;
         rip_ff    <= in_data.rip;
         scale_ff  <= in_data.scale;
         region_ff <= region_in;
         step_ff   <= step_in;
      end
   end

   assign out_valid         = v5_ff;
   assign out_scope         = scope_ff;
   assign out_shape_found   = found_ff;
   assign out_has_index_reg = idx_ff;
   assign out_stack_based   = stk_ff;
   assign out_rip_relative  = rip_ff;
   assign out_scale_factor  = scale_ff;
   assign out_region_offset = region_ff;
   assign out_stream_step   = step_ff;

endmodule

`default_nettype wire

// File: rtl/memory_operand_scope_classifier_unit.sv
// ----------------------------------------------------------------------------
// memory_operand_scope_classifier_unit
// Decodes the memory operand of one x86-64 instruction per beat and
// classifies its access scope, region offset and stream step.
// ----------------------------------------------------------------------------
// One instruction is accepted every cycle while req_stall is low. Two stages
// scan the legacy and rex prefix run, two fetch and decode opcode, modrm and
// sib, and one classifies the scope into the output register. A stall on the
// result side holds each occupied stage in place and pushes back through
// req_stall; nothing is dropped or repeated. The stream padding register sits
// at byte address 0 of the APB port and reads back its value.
`default_nettype none

module memory_operand_scope_classifier_unit
   import mosc_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_bytes_lo,
   input  logic [63:0] req_bytes_mid_lo,
   input  logic [63:0] req_bytes_mid_hi,
   input  logic [63:0] req_bytes_hi,
   input  logic [5:0]  req_byte_count,
   input  logic [6:0]  req_access_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_scope,
   output logic        rsp_shape_found,
   output logic        rsp_has_index_reg,
   output logic        rsp_stack_based,
   output logic        rsp_rip_relative,
   output logic [3:0]  rsp_scale_factor,
   output logic [41:0] rsp_region_offset,
   output logic [15:0] rsp_stream_step,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] padding_ff;
   logic        scan_ready, scan_valid;
   scan_type    scan_data;
   logic        shape_ready, shape_valid;
   shape_type   shape_data;
   logic        cls_ready;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         padding_ff <= 16'd0;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == ADDR_STREAM_PADDING) begin
         padding_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr[2] == ADDR_STREAM_PADDING) ? {16'd0, padding_ff} : 32'd0;

   mosc_prefix_scan #(
      .MAX_BYTES (MAX_BYTES)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (scan_ready),
      .bytes_lo     (req_bytes_lo),
      .bytes_mid_lo (req_bytes_mid_lo),
      .bytes_mid_hi (req_bytes_mid_hi),
      .bytes_hi     (req_bytes_hi),
      .byte_count   (req_byte_count),
      .access_bytes (req_access_bytes),
      .out_valid    (scan_valid),
      .out_data     (scan_data),
      .out_ready    (shape_ready)
   );

   mosc_shape_decode u_shape (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scan_valid),
      .in_ready  (shape_ready),
      .in_data   (scan_data),
      .out_valid (shape_valid),
      .out_data  (shape_data),
      .out_ready (cls_ready)
   );

   mosc_scope_classify u_cls (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (shape_valid),
      .in_ready          (cls_ready),
      .in_data           (shape_data),
      .stream_padding    (padding_ff),
      .out_valid         (rsp_valid),
      .out_stall         (rsp_stall),
      .out_scope         (rsp_scope),
      .out_shape_found   (rsp_shape_found),
      .out_has_index_reg (rsp_has_index_reg),
      .out_stack_based   (rsp_stack_based),
      .out_rip_relative  (rsp_rip_relative),
      .out_scale_factor  (rsp_scale_factor),
      .out_region_offset (rsp_region_offset),
      .out_stream_step   (rsp_stream_step)
   );

   assign req_stall = !scan_ready;

   a_stack_scope: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scope == SCOPE_STACK |-> rsp_stack_based)
      else $error("stack scope without stack base");

   a_no_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_shape_found |-> !rsp_has_index_reg && !rsp_stack_based
         && !rsp_rip_relative && rsp_scale_factor == 4'd1)
      else $error("shape flags set without a decoded shape");

   a_array_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scope == SCOPE_ARRAY |-> rsp_has_index_reg
         && rsp_stream_step >= 16'd8)
      else $error("array scope with bad step or no index");

endmodule

`default_nettype wire
